>>> rtl/core/prc_pkg.sv
// ----------------------------------------------------------------------------
// prc_pkg
// Shared types, constants and helpers of the perspective remap coordinate
// generator.
// ----------------------------------------------------------------------------
package prc_pkg;

    localparam int SUB_BITS_DEF   = 5;
    localparam int COORD_BITS_DEF = 12;
    localparam int COEF_W         = 32;
    localparam int FIELD_W        = 12;
    localparam int QUO_W          = 33;
    localparam int PRE_SHIFT      = 6;
    localparam int MAP_W          = 16;
    localparam int ALPHA_W        = 10;
    localparam int CFG_AW         = 6;
    localparam int CFG_DW         = 64;

    typedef enum logic [2:0] {
        REG_M0_M1 = 3'd0,
        REG_M2_M3 = 3'd1,
        REG_M4_M5 = 3'd2,
        REG_M6_M7 = 3'd3,
        REG_M8    = 3'd4,
        REG_MODE  = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic signed [COEF_W-1:0] m0;
        logic signed [COEF_W-1:0] m1;
        logic signed [COEF_W-1:0] m2;
        logic signed [COEF_W-1:0] m3;
        logic signed [COEF_W-1:0] m4;
        logic signed [COEF_W-1:0] m5;
        logic signed [COEF_W-1:0] m6;
        logic signed [COEF_W-1:0] m7;
        logic signed [COEF_W-1:0] m8;
        logic                     interp;
    } t_coef;

    function automatic logic signed [MAP_W-1:0] sat16(input logic signed [COEF_W-1:0] v);
        logic signed [MAP_W-1:0] res;
        if (v > 32'sd32767) begin
            res = 16'sh7FFF;
        end else if (v < -32'sd32768) begin
            res = 16'sh8000;
        end else begin
            res = v[MAP_W-1:0];
        end
        return res;
    endfunction

endpackage

>>> rtl/core/prc_coord_if.sv
// ----------------------------------------------------------------------------
// prc_coord_if
// Destination coordinate channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface prc_coord_if;
    logic        valid;
    logic        ready;
    logic [11:0] dst_x;
    logic [11:0] dst_y;

    modport source (output valid, output dst_x, output dst_y, input ready);
    modport sink   (input valid, input dst_x, input dst_y, output ready);
endinterface

>>> rtl/core/prc_map_if.sv
// ----------------------------------------------------------------------------
// prc_map_if
// Source map coordinate channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface prc_map_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] map_x;
    logic signed [15:0] map_y;
    logic [9:0]         alpha;

    modport source (output valid, output map_x, output map_y, output alpha, input ready);
    modport sink   (input valid, input map_x, input map_y, input alpha, output ready);
endinterface

>>> rtl/core/perspective_remap_coordinate_gen.sv
// ----------------------------------------------------------------------------
// perspective_remap_coordinate_gen
// Maps destination pixel coordinates to source coordinates under a 3x3
// fixed-point homography.
// ----------------------------------------------------------------------------
// Usage:
// Destination coordinates enter on i_coord and source coordinates leave on
// o_map, both valid/ready channels; one transfer in gives one transfer out,
// in order. The coefficients and the mode sit in an APB register file, with
// register i at byte address 8*i; write them only while the pipeline is empty.
// An input transfer passes through the multiply-and-add stages, a setup
// stage and 33 quotient-bit stages of the divider, a rounding stage and
// one output register before its result appears on o_map.
// Throughput is one coordinate per cycle while o_map is not stalled, set by
// the one-bit-per-stage divider that takes a new dividend every cycle.
// The whole pipeline advances together; when o_map is stalled with a result
// held, i_coord.ready drops and every stage keeps its contents.
// Reset clears all valid bits and loads the identity homography in nearest
// mode.
// ----------------------------------------------------------------------------
module perspective_remap_coordinate_gen
    import prc_pkg::*;
#(
    parameter int SUB_BITS   = SUB_BITS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    prc_coord_if.sink         i_coord,
    prc_map_if.source         o_map,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready
);

    localparam int PW   = COEF_W + 3 + COORD_BITS;
    localparam int KMAX = PRE_SHIFT + SUB_BITS;
    localparam int AXW  = ALPHA_W + 2 * SUB_BITS;

    t_coef coef;
    logic  en;

    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;

    logic               mac_vld;
    logic [PW-1:0]      mac_den;
    logic [1:0][PW-1:0] mac_num;
    logic [1:0]         mac_neg;
    logic               mac_zero;

    logic                   div_vld;
    logic                   div_zero;
    logic [1:0][COEF_W-1:0] div_quo;

    logic               r_out_vld;
    logic signed [15:0] r_map_x;
    logic signed [15:0] r_map_y;
    logic [9:0]         r_alpha;

    logic signed [15:0] n_map [2];
    logic [9:0]         n_alpha;
    logic [AXW-1:0]     alpha_ext;
    logic signed [COEF_W-1:0] q_s [2];

    prc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_coef  (coef)
    );

    assign en            = !r_out_vld || o_map.ready;
    assign i_coord.ready = en;

    assign x = COORD_BITS'({{COORD_BITS{1'b0}}, i_coord.dst_x});
    assign y = COORD_BITS'({{COORD_BITS{1'b0}}, i_coord.dst_y});

    prc_mac #(
        .COORD_BITS (COORD_BITS),
        .PW         (PW)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_coord.valid),
        .i_x     (x),
        .i_y     (y),
        .i_coef  (coef),
        .o_valid (mac_vld),
        .o_den   (mac_den),
        .o_num   (mac_num),
        .o_neg   (mac_neg),
        .o_zero  (mac_zero)
    );

    prc_div #(
        .PW   (PW),
        .KMAX (KMAX)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_interp (coef.interp),
        .i_valid  (mac_vld),
        .i_den    (mac_den),
        .i_num    (mac_num),
        .i_neg    (mac_neg),
        .i_zero   (mac_zero),
        .o_valid  (div_vld),
        .o_zero   (div_zero),
        .o_quo    (div_quo)
    );

    // In subpixel mode the low SUB_BITS bits are the fraction and the rest
    // is the floor of the coordinate.
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            q_s[l] = $signed(div_quo[l]);
            if (div_zero) begin
                n_map[l] = '0;
            end else if (coef.interp) begin
                n_map[l] = sat16(q_s[l] >>> SUB_BITS);
            end else begin
                n_map[l] = sat16(q_s[l]);
            end
        end
        alpha_ext = {{ALPHA_W{1'b0}}, div_quo[1][SUB_BITS-1:0], div_quo[0][SUB_BITS-1:0]};
        n_alpha   = (coef.interp && !div_zero) ? alpha_ext[ALPHA_W-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_map_x <= n_map[0];
            r_map_y <= n_map[1];
            r_alpha <= n_alpha;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= div_vld;
        end
    end

    assign o_map.valid = r_out_vld;
    assign o_map.map_x = r_map_x;
    assign o_map.map_y = r_map_y;
    assign o_map.alpha = r_alpha;

endmodule

>>> rtl/core/prc_cfg.sv
// ----------------------------------------------------------------------------
// prc_cfg
// APB register file holding the homography coefficients and the mode.
// ----------------------------------------------------------------------------
module prc_cfg
    import prc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready,
    output t_coef             o_coef
);

    // Identity homography in nearest mode.
    localparam t_coef COEF_RST = '{
        m0: 32'sh0100_0000,
        m4: 32'sh0100_0000,
        m8: 32'sh0100_0000,
        default: '0
    };

    t_coef    r_coef;
    t_coef    n_coef;
    t_reg_idx idx;

    assign idx    = t_reg_idx'(paddr[CFG_AW-1:3]);
    assign pready = 1'b1;
    assign o_coef = r_coef;

    always_comb begin
        n_coef = r_coef;
        if (psel && penable && pwrite) begin
            unique case (idx)
                REG_M0_M1: begin
                    n_coef.m0 = pwdata[31:0];
                    n_coef.m1 = pwdata[63:32];
                end
                REG_M2_M3: begin
                    n_coef.m2 = pwdata[31:0];
                    n_coef.m3 = pwdata[63:32];
                end
                REG_M4_M5: begin
                    n_coef.m4 = pwdata[31:0];
                    n_coef.m5 = pwdata[63:32];
                end
                REG_M6_M7: begin
                    n_coef.m6 = pwdata[31:0];
                    n_coef.m7 = pwdata[63:32];
                end
                REG_M8:   n_coef.m8     = pwdata[31:0];
                REG_MODE: n_coef.interp = pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_M0_M1: prdata = {r_coef.m1, r_coef.m0};
            REG_M2_M3: prdata = {r_coef.m3, r_coef.m2};
            REG_M4_M5: prdata = {r_coef.m5, r_coef.m4};
            REG_M6_M7: prdata = {r_coef.m7, r_coef.m6};
            REG_M8:    prdata = {{32{r_coef.m8[31]}}, r_coef.m8};
            REG_MODE:  prdata = {63'd0, r_coef.interp};
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= COEF_RST;
        end else begin
            r_coef <= n_coef;
        end
    end

endmodule

>>> rtl/core/prc_mac.sv
// ----------------------------------------------------------------------------
// prc_mac
// Three-stage front end: products, sums, then magnitudes and signs for the
// divider.
// ----------------------------------------------------------------------------
module prc_mac
    import prc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int PW         = COEF_W + 3 + COORD_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [COORD_BITS-1:0] i_x,
    input  logic [COORD_BITS-1:0] i_y,
    input  t_coef                 i_coef,
    output logic                  o_valid,
    output logic [PW-1:0]         o_den,
    output logic [1:0][PW-1:0]    o_num,
    output logic [1:0]            o_neg,
    output logic                  o_zero
);

    localparam int PRW = COEF_W + COORD_BITS + 1;

    logic signed [COORD_BITS:0] sx;
    logic signed [COORD_BITS:0] sy;

    // Stage 1: products.
    logic signed [PRW-1:0]    r_p [6];
    logic signed [COEF_W-1:0] r_c2;
    logic signed [COEF_W-1:0] r_c5;
    logic signed [COEF_W-1:0] r_c8;
    logic                     r_v1;

    // Stage 2: sums.
    logic signed [PW-1:0] r_w;
    logic signed [PW-1:0] r_nx;
    logic signed [PW-1:0] r_ny;
    logic                 r_v2;

    // Stage 3: magnitudes.
    logic [PW-1:0]      r_den;
    logic [1:0][PW-1:0] r_num;
    logic [1:0]         r_neg;
    logic               r_zero;
    logic               r_v3;

    logic signed [PW-1:0] pe [6];

    assign sx = $signed({1'b0, i_x});
    assign sy = $signed({1'b0, i_y});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0] <= i_coef.m6 * sx;
            r_p[1] <= i_coef.m7 * sy;
            r_p[2] <= i_coef.m0 * sx;
            r_p[3] <= i_coef.m1 * sy;
            r_p[4] <= i_coef.m3 * sx;
            r_p[5] <= i_coef.m4 * sy;
            r_c2   <= i_coef.m2;
            r_c5   <= i_coef.m5;
            r_c8   <= i_coef.m8;
        end
    end

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            pe[i] = {{(PW-PRW){r_p[i][PRW-1]}}, r_p[i]};
        end
    end

    // The constant terms are aligned to the binary point of their products.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_w  <= pe[0] + pe[1] + $signed({{(PW-COEF_W-6){r_c8[COEF_W-1]}}, r_c8, 6'd0});
            r_nx <= pe[2] + pe[3] + $signed({{(PW-COEF_W-8){r_c2[COEF_W-1]}}, r_c2, 8'd0});
            r_ny <= pe[4] + pe[5] + $signed({{(PW-COEF_W-8){r_c5[COEF_W-1]}}, r_c5, 8'd0});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero   <= (r_w == '0);
            r_den    <= r_w[PW-1] ? PW'(-r_w) : PW'(r_w);
            r_num[0] <= r_nx[PW-1] ? PW'(-r_nx) : PW'(r_nx);
            r_num[1] <= r_ny[PW-1] ? PW'(-r_ny) : PW'(r_ny);
            r_neg[0] <= r_nx[PW-1] ^ r_w[PW-1];
            r_neg[1] <= r_ny[PW-1] ^ r_w[PW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    assign o_valid = r_v3;
    assign o_den   = r_den;
    assign o_num   = r_num;
    assign o_neg   = r_neg;
    assign o_zero  = r_zero;

endmodule

>>> rtl/core/prc_div.sv
// ----------------------------------------------------------------------------
// prc_div
// Pipelined restoring divider for both coordinates, one quotient bit per
// stage, with round half to even and saturation to 32 bits.
// ----------------------------------------------------------------------------
module prc_div
    import prc_pkg::*;
#(
    parameter int PW   = 47,
    parameter int KMAX = PRE_SHIFT + SUB_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_interp,
    input  logic                         i_valid,
    input  logic [PW-1:0]                i_den,
    input  logic [1:0][PW-1:0]           i_num,
    input  logic [1:0]                   i_neg,
    input  logic                         i_zero,
    output logic                         o_valid,
    output logic                         o_zero,
    output logic [1:0][COEF_W-1:0]       o_quo
);

    localparam int DW = PW + KMAX;
    localparam int CW = PW + QUO_W;

    logic [PW-1:0]    r_rem [0:QUO_W][2];
    logic [QUO_W-1:0] r_dq  [0:QUO_W][2];
    logic [PW-1:0]    r_den [0:QUO_W];
    logic [1:0]       r_ovf [0:QUO_W];
    logic [1:0]       r_neg [0:QUO_W];
    logic             r_zero [0:QUO_W];
    logic             r_vld  [0:QUO_W];

    logic [1:0][COEF_W-1:0] r_quo;
    logic                   r_zero_o;
    logic                   r_vld_o;

    logic [DW-1:0] dvd [2];
    logic [1:0]    ovf;

    // Dividend scaled by 2^6, or by 2^(6+SUB_BITS) in subpixel mode; a quotient of 2^33 or more saturates anyway.
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            dvd[l] = i_interp ? (DW'(i_num[l]) << KMAX) : (DW'(i_num[l]) << PRE_SHIFT);
            ovf[l] = CW'(dvd[l]) >= {i_den, {QUO_W{1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < 2; l++) begin
                r_rem[0][l] <= PW'(dvd[l][DW-1:QUO_W]);
                r_dq[0][l]  <= dvd[l][QUO_W-1:0];
            end
            r_den[0]  <= i_den;
            r_ovf[0]  <= ovf;
            r_neg[0]  <= i_neg;
            r_zero[0] <= i_zero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    for (genvar s = 0; s < QUO_W; s++) begin : g_step
        logic [PW:0]   trial [2];
        logic [1:0]    ge;

        always_comb begin
            for (int l = 0; l < 2; l++) begin
                trial[l] = {r_rem[s][l], r_dq[s][l][QUO_W-1]};
                ge[l]    = trial[l] >= {1'b0, r_den[s]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int l = 0; l < 2; l++) begin
                    r_rem[s+1][l] <= ge[l] ? PW'(trial[l] - {1'b0, r_den[s]}) : PW'(trial[l]);
                    r_dq[s+1][l]  <= {r_dq[s][l][QUO_W-2:0], ge[l]};
                end
                r_den[s+1]  <= r_den[s];
                r_ovf[s+1]  <= r_ovf[s];
                r_neg[s+1]  <= r_neg[s];
                r_zero[s+1] <= r_zero[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[s+1] <= r_vld[s];
            end
        end
    end

    logic [PW:0]       twor [2];
    logic [1:0]        up;
    logic [QUO_W:0]    qr [2];
    logic [COEF_W-1:0] sat [2];

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            twor[l] = {r_rem[QUO_W][l], 1'b0};
            up[l]   = (twor[l] > {1'b0, r_den[QUO_W]})
                   || ((twor[l] == {1'b0, r_den[QUO_W]}) && r_dq[QUO_W][l][0]);
            qr[l]   = {1'b0, r_dq[QUO_W][l]} + (QUO_W+1)'(up[l]);
            if (r_ovf[QUO_W][l]) begin
                sat[l] = r_neg[QUO_W][l] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else if (r_neg[QUO_W][l]) begin
                sat[l] = (qr[l] > (QUO_W+1)'(34'h0_8000_0000)) ? 32'h8000_0000
                                                              : (~qr[l][31:0] + 32'd1);
            end else begin
                sat[l] = (qr[l] > (QUO_W+1)'(34'h0_7FFF_FFFF)) ? 32'h7FFF_FFFF
                                                              : qr[l][31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quo[0] <= sat[0];
            r_quo[1] <= sat[1];
            r_zero_o <= r_zero[QUO_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_o <= 1'b0;
        end else if (i_en) begin
            r_vld_o <= r_vld[QUO_W];
        end
    end

    assign o_valid = r_vld_o;
    assign o_zero  = r_zero_o;
    assign o_quo   = r_quo;

endmodule

>>> rtl/core/prc_checker.sv
// ----------------------------------------------------------------------------
// prc_checker
// Port-level checks of the coordinate generator, bound to the top level.
// ----------------------------------------------------------------------------
module prc_checker
    import prc_pkg::*;
#(
    parameter int SUB_BITS = SUB_BITS_DEF
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic signed [15:0] i_map_x,
    input logic [9:0]        i_alpha
);

    // A held result must not drop before its transfer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_map_x)))
        else $error("result dropped or changed while stalled");

    // The input side stalls exactly when a result is held back.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (!i_out_valid || i_out_ready))
        else $error("input ready does not follow output stall");

    // Nothing comes out in the cycle after reset.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result presented right after reset");

    // Alpha never carries bits above its two fractions.
    a_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((20'(i_alpha) >> (2 * SUB_BITS)) == 20'd0))
        else $error("alpha out of range");

endmodule

bind perspective_remap_coordinate_gen prc_checker #(
    .SUB_BITS (SUB_BITS)
) u_prc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_coord.ready),
    .i_out_valid (o_map.valid),
    .i_out_ready (o_map.ready),
    .i_map_x     (o_map.map_x),
    .i_alpha     (o_map.alpha)
);
